>>> src/assert_macros.svh
// Assertion helpers shared by the decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

>>> src/rsrd_pkg.sv
package rsrd_pkg;

  localparam int RES_PER_ENT = 3;
  localparam int QDEPTH      = 2;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_WIDTH    = 2'd1;
  localparam logic [1:0] ERR_ZERODUMP = 2'd2;
  localparam logic [1:0] ERR_OVERRUN  = 2'd3;

  // One pixel write command.
  typedef struct packed {
    logic [1:0]  channel;
    logic [15:0] start_x;
    logic [6:0]  fill_count;
    logic [7:0]  value;
    logic        line_done;
    logic [1:0]  error_code;
  } res_t;

  // All writes caused by one input byte; res[0] goes out first.
  typedef struct packed {
    res_t [RES_PER_ENT-1:0] res;
    logic [1:0]             cnt;
  } ent_t;

endpackage

>>> src/rsrd_front.sv
`include "assert_macros.svh"
module rsrd_front #(
  parameter int MAX_WIDTH = 65535
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_data_byte,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [15:0]      cfg_line_width,
  input  logic             q_full,
  output logic             push,
  output rsrd_pkg::ent_t   ent
);

  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_PRE1  = 3'd1;
  localparam logic [2:0] PH_PRE2  = 3'd2;
  localparam logic [2:0] PH_PRE3  = 3'd3;
  localparam logic [2:0] PH_COUNT = 3'd4;
  localparam logic [2:0] PH_DATA  = 3'd5;
  localparam logic [2:0] PH_FLAT  = 3'd6;

  localparam logic [15:0] MAX_W  = 16'(MAX_WIDTH);
  localparam logic [7:0]  MARK   = 8'd2;
  localparam logic [7:0]  RUN_TH = 8'd128;

  typedef struct packed {
    logic [1:0]  ch;
    logic [15:0] col;
    logic        done;
  } pos_t;

  function automatic pos_t flat_next(input logic [1:0] ch, input logic [15:0] col,
                                     input logic [15:0] w);
    pos_t p;
    p.done = (ch == 2'd3) && (({1'b0, col} + 17'd1) >= {1'b0, w});
    if (p.done) begin
      p.ch  = 2'd0;
      p.col = 16'd0;
    end else if (ch == 2'd3) begin
      p.ch  = 2'd0;
      p.col = col + 16'd1;
    end else begin
      p.ch  = ch + 2'd1;
      p.col = col;
    end
    return p;
  endfunction

  function automatic rsrd_pkg::res_t mk_res(input logic [1:0] ch, input logic [15:0] col,
                                            input logic [6:0] cnt, input logic [7:0] val,
                                            input logic done, input logic [1:0] err);
    rsrd_pkg::res_t r;
    r.channel    = ch;
    r.start_x    = col;
    r.fill_count = cnt;
    r.value      = val;
    r.line_done  = done;
    r.error_code = err;
    return r;
  endfunction

  logic [15:0] eff_w_r, eff_w_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic [1:0]  ch_r, ch_nxt;
  logic [15:0] col_r, col_nxt;
  logic [6:0]  pending_r, pending_nxt;
  logic        in_run_r, in_run_nxt;
  logic        locked_r, locked_nxt;

  logic        accept;
  pos_t        f1, f2, f3;
  logic [6:0]  rle_n;
  logic [16:0] rle_sum;
  logic        chan_end;
  logic [7:0]  cnt8;
  logic        over;
  rsrd_pkg::res_t fail_w, fail_z, fail_o;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;

  always_comb begin
    if (cfg_line_width == 16'd0) begin
      eff_w_nxt = 16'd1;
    end else if (cfg_line_width > MAX_W) begin
      eff_w_nxt = MAX_W;
    end else begin
      eff_w_nxt = cfg_line_width;
    end
  end

  assign f1 = flat_next(ch_r, col_r, eff_w_r);
  assign f2 = flat_next(f1.ch, f1.col, eff_w_r);
  assign f3 = flat_next(f2.ch, f2.col, eff_w_r);

  assign rle_n    = in_run_r ? (pending_r + 7'd1) : 7'd1;
  assign rle_sum  = {1'b0, col_r} + 17'(rle_n);
  assign chan_end = rle_sum >= {1'b0, eff_w_r};

  assign cnt8 = (in_data_byte > RUN_TH) ? (in_data_byte - RUN_TH) : in_data_byte;
  assign over = ({1'b0, col_r} + 17'(cnt8)) > {1'b0, eff_w_r};

  assign fail_w = mk_res(2'd0, 16'd0, 7'd0, 8'd0, 1'b0, rsrd_pkg::ERR_WIDTH);
  assign fail_z = mk_res(2'd0, 16'd0, 7'd0, 8'd0, 1'b0, rsrd_pkg::ERR_ZERODUMP);
  assign fail_o = mk_res(2'd0, 16'd0, 7'd0, 8'd0, 1'b0, rsrd_pkg::ERR_OVERRUN);

  always_comb begin
    phase_nxt   = phase_r;
    hi_nxt      = hi_r;
    ch_nxt      = ch_r;
    col_nxt     = col_r;
    pending_nxt = pending_r;
    in_run_nxt  = in_run_r;
    locked_nxt  = locked_r;
    ent         = '0;
    if (accept && !locked_r) begin
      case (phase_r)
        PH_PRE1: begin
          if (in_data_byte == MARK) begin
            phase_nxt = PH_PRE2;
          end else begin
            // replay the held marker, then this byte
            ent.res[0] = mk_res(ch_r, col_r, 7'd1, MARK, f1.done, rsrd_pkg::ERR_NONE);
            ent.res[1] = mk_res(f1.ch, f1.col, 7'd1, in_data_byte, f2.done,
                                rsrd_pkg::ERR_NONE);
            ent.cnt    = 2'd2;
            ch_nxt     = f2.ch;
            col_nxt    = f2.col;
            phase_nxt  = f2.done ? PH_START : PH_FLAT;
          end
        end
        PH_PRE2: begin
          if (!in_data_byte[7]) begin
            hi_nxt    = in_data_byte;
            phase_nxt = PH_PRE3;
          end else begin
            ent.res[0] = mk_res(ch_r, col_r, 7'd1, MARK, f1.done, rsrd_pkg::ERR_NONE);
            ent.res[1] = mk_res(f1.ch, f1.col, 7'd1, MARK, f2.done, rsrd_pkg::ERR_NONE);
            ent.res[2] = mk_res(f2.ch, f2.col, 7'd1, in_data_byte, f3.done,
                                rsrd_pkg::ERR_NONE);
            ent.cnt    = 2'd3;
            ch_nxt     = f3.ch;
            col_nxt    = f3.col;
            phase_nxt  = f3.done ? PH_START : PH_FLAT;
          end
        end
        PH_PRE3: begin
          if ({hi_r, in_data_byte} != eff_w_r) begin
            ent.res[0] = fail_w;
            ent.cnt    = 2'd1;
            locked_nxt = 1'b1;
          end else begin
            ch_nxt    = 2'd0;
            col_nxt   = 16'd0;
            phase_nxt = PH_COUNT;
          end
        end
        PH_COUNT: begin
          in_run_nxt = in_data_byte > RUN_TH;
          if (cnt8 == 8'd0) begin
            ent.res[0] = fail_z;
            ent.cnt    = 2'd1;
            locked_nxt = 1'b1;
          end else if (over) begin
            ent.res[0] = fail_o;
            ent.cnt    = 2'd1;
            locked_nxt = 1'b1;
          end else begin
            pending_nxt = 7'(cnt8 - 8'd1);
            phase_nxt   = PH_DATA;
          end
        end
        PH_DATA: begin
          ent.res[0] = mk_res(ch_r, col_r, rle_n, in_data_byte,
                              chan_end && (ch_r == 2'd3), rsrd_pkg::ERR_NONE);
          ent.cnt    = 2'd1;
          if (chan_end) begin
            // channel complete: drop any dump bytes still due
            col_nxt   = 16'd0;
            ch_nxt    = ch_r + 2'd1;
            phase_nxt = (ch_r == 2'd3) ? PH_START : PH_COUNT;
          end else begin
            col_nxt = rle_sum[15:0];
            if (in_run_r || (pending_r == 7'd0)) begin
              phase_nxt = PH_COUNT;
            end else begin
              pending_nxt = pending_r - 7'd1;
            end
          end
        end
        PH_FLAT: begin
          ent.res[0] = mk_res(ch_r, col_r, 7'd1, in_data_byte, f1.done, rsrd_pkg::ERR_NONE);
          ent.cnt    = 2'd1;
          ch_nxt     = f1.ch;
          col_nxt    = f1.col;
          phase_nxt  = f1.done ? PH_START : PH_FLAT;
        end
        default: begin
          if ((eff_w_r >= 16'd8) && (eff_w_r < 16'd32768) && (in_data_byte == MARK)) begin
            phase_nxt = PH_PRE1;
          end else begin
            ent.res[0] = mk_res(ch_r, col_r, 7'd1, in_data_byte, f1.done,
                                rsrd_pkg::ERR_NONE);
            ent.cnt    = 2'd1;
            ch_nxt     = f1.ch;
            col_nxt    = f1.col;
            phase_nxt  = f1.done ? PH_START : PH_FLAT;
          end
        end
      endcase
    end
  end

  assign push = ent.cnt != 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r   <= 16'd8;
      phase_r   <= PH_START;
      hi_r      <= 8'd0;
      ch_r      <= 2'd0;
      col_r     <= 16'd0;
      pending_r <= 7'd0;
      in_run_r  <= 1'b0;
      locked_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        eff_w_r <= eff_w_nxt;
      end
      phase_r   <= phase_nxt;
      hi_r      <= hi_nxt;
      ch_r      <= ch_nxt;
      col_r     <= col_nxt;
      pending_r <= pending_nxt;
      in_run_r  <= in_run_nxt;
      locked_r  <= locked_nxt;
    end
  end

  `ASSERT_ALWAYS(a_lock_sticky, clk, rst_n, locked_r |=> locked_r)
  `ASSERT_ALWAYS(a_error_alone, clk, rst_n, (push && (ent.res[0].error_code != rsrd_pkg::ERR_NONE)) |-> (ent.cnt == 2'd1))

endmodule

>>> src/rsrd_queue.sv
`include "assert_macros.svh"
module rsrd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rsrd_pkg::ent_t wr_ent,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output rsrd_pkg::ent_t head
);

  localparam int PTR_W = (rsrd_pkg::QDEPTH > 1) ? $clog2(rsrd_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(rsrd_pkg::QDEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(rsrd_pkg::QDEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(rsrd_pkg::QDEPTH);

  rsrd_pkg::ent_t     mem_r [rsrd_pkg::QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full  = cnt_r == CNT_FULL;
  assign empty = cnt_r == '0;
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk, rst_n, push && full)
  `ASSERT_NEVER(a_no_underflow, clk, rst_n, pop && empty)

endmodule

>>> src/rsrd_back.sv
`include "assert_macros.svh"
module rsrd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  rsrd_pkg::ent_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     out_channel,
  output logic [15:0]    out_start_x,
  output logic [6:0]     out_fill_count,
  output logic [7:0]     out_value,
  output logic           out_line_done,
  output logic [1:0]     out_error_code,
  output logic           out_last
);

  logic [1:0]     sub_r, sub_nxt;
  logic           out_valid_r;
  rsrd_pkg::res_t res_r;
  logic           last_r;
  logic           load;
  logic           is_last;

  assign load    = (!out_valid_r || out_ready) && !q_empty;
  assign is_last = sub_r == (head.cnt - 2'd1);
  assign pop     = load && is_last;
  assign sub_nxt = pop ? 2'd0 : (load ? sub_r + 2'd1 : sub_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sub_r       <= 2'd0;
    end else begin
      sub_r <= sub_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= head.res[sub_r];
      last_r <= is_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_channel    = res_r.channel;
  assign out_start_x    = res_r.start_x;
  assign out_fill_count = res_r.fill_count;
  assign out_value      = res_r.value;
  assign out_line_done  = res_r.line_done;
  assign out_error_code = res_r.error_code;
  assign out_last       = last_r;

  `ASSERT_ALWAYS(a_head_nonempty, clk, rst_n, !q_empty |-> ((head.cnt != 2'd0) && (sub_r < head.cnt)))

endmodule

>>> src/rgbe_scanline_rle_decoder_core.sv
// RGBE scanline decoder for the new-style run-length scheme. Feed the encoded
// scanline stream one byte per transaction on in_*; each byte yields zero to
// three pixel write commands on out_* (channel, start column, column count,
// byte value), with out_last marking the final write of that byte and
// out_line_done the write that completes a scanline. A line is decoded as
// runs and dumps per channel when the width is 8..32767 and it opens with
// 2,2,hi,lo; otherwise bytes are placed flat, and a failed prefix replays its
// held bytes as flat data. cfg_line_width sets the pixels per line (zero acts
// as one, larger than MAX_WIDTH is clipped); write it only while the block is
// idle. A width mismatch, a zero dump count or an overrun gives one write
// with a nonzero out_error_code and then every byte is swallowed until reset.
// Rate: the classifier takes one byte per cycle unless the queue is full;
// the output register issues one write per cycle when out_ready allows and
// the queue holds data; a two-entry queue between them absorbs the bytes
// that cause more than one write. No clearing pass is needed after reset.
module rgbe_scanline_rle_decoder_core #(
  parameter int MAX_WIDTH = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_line_width,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_channel,
  output logic [15:0] out_start_x,
  output logic [6:0]  out_fill_count,
  output logic [7:0]  out_value,
  output logic        out_line_done,
  output logic [1:0]  out_error_code,
  output logic        out_last
);

  logic           q_full;
  logic           q_empty;
  logic           push;
  logic           pop;
  rsrd_pkg::ent_t wr_ent;
  rsrd_pkg::ent_t head;

  // Classify each byte and build its write commands.
  rsrd_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_line_width(cfg_line_width),
    .q_full        (q_full),
    .push          (push),
    .ent           (wr_ent)
  );

  // Hold command groups so either side can stall on its own.
  rsrd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wr_ent(wr_ent),
    .full  (q_full),
    .pop   (pop),
    .empty (q_empty),
    .head  (head)
  );

  // Issue the writes of each group, one per transaction.
  rsrd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_channel   (out_channel),
    .out_start_x   (out_start_x),
    .out_fill_count(out_fill_count),
    .out_value     (out_value),
    .out_line_done (out_line_done),
    .out_error_code(out_error_code),
    .out_last      (out_last)
  );

endmodule
